[src/btpc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared constants, types and helpers of the barometric compensation block.
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int unsigned RawW   = 20;
  localparam int unsigned WordW  = 32;
  localparam int unsigned TempW  = 24;
  localparam int unsigned DivW   = 32;
  localparam int unsigned QDepth = 4;
  localparam int unsigned AddrW  = 5;

  localparam logic [AddrW-1:0] RegTemp      = 5'd0;
  localparam logic [AddrW-1:0] RegPressLow  = 5'd8;
  localparam logic [AddrW-1:0] RegPressHigh = 5'd16;
  localparam logic [AddrW-1:0] RegPressNine = 5'd24;

  localparam logic [31:0] PressOffset = 32'd64000;
  localparam logic [31:0] PressBase   = 32'd1048576;
  localparam logic [31:0] PressScale  = 32'd3125;
  localparam logic [31:0] HalfRange   = 32'h8000_0000;
  localparam logic [31:0] DivBias     = 32'd32768;
  localparam logic [31:0] TempRound   = 32'd128;

  typedef struct packed {
    logic [15:0] t1, t2, t3;
    logic [15:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  } coeff_t;

  // Work handed from the front part to the divider side.
  typedef struct packed {
    logic [TempW-1:0] temp;
    logic [31:0]      fine;
    logic [31:0]      dividend;
    logic [31:0]      divisor;
    logic             dbl_after;
  } job_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

endpackage
`default_nettype wire

[src/btpc_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_raw_if / btpc_res_if
// Valid/ready channels carrying raw readings in and compensated results out.
// ----------------------------------------------------------------------------
interface btpc_raw_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface btpc_res_if;
  logic        valid;
  logic        ready;
  logic signed [23:0] temperature;
  logic signed [31:0] fine_temperature;
  logic [31:0] pressure;
  logic        pressure_invalid;
  modport source (output valid, temperature, fine_temperature, pressure,
                  pressure_invalid, input ready);
  modport sink   (input valid, temperature, fine_temperature, pressure,
                  pressure_invalid, output ready);
endinterface
`default_nettype wire

[src/baro_temp_pressure_compensation.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Integer temperature and pressure compensation of a digital barometer.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  raw     | in  | raw_temperature, raw_pressure
//  res     | out | temperature, fine_temperature, pressure, pressure_invalid
//  apb     | in  | four coefficient registers at byte 8*i
// One beat per cycle sustained while res.ready stays high; the path is 7 front
// stages, the queue and 35 back stages.
// The 32-stage divider, one quotient bit per stage, makes up most of the path.
// Reset clears all valid bits and coefficients; raw.ready is low during reset.
// The front stalls only when its last stage holds a beat and the queue is
// full with no read; the back stalls on res.ready.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation #(
  parameter int unsigned QUEUE_DEPTH = btpc_pkg::QDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  btpc_raw_if.sink         raw,
  btpc_res_if.source       res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [btpc_pkg::AddrW-1:0] paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH+1);

  logic [47:0] r_temp; logic [63:0] r_plo, r_phi; logic [15:0] r_p9;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_temp <= '0; r_plo <= '0; r_phi <= '0; r_p9 <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        btpc_pkg::RegTemp:      r_temp <= pwdata[47:0];
        btpc_pkg::RegPressLow:  r_plo  <= pwdata;
        btpc_pkg::RegPressHigh: r_phi  <= pwdata;
        btpc_pkg::RegPressNine: r_p9   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      btpc_pkg::RegTemp:      prdata = {16'd0, r_temp};
      btpc_pkg::RegPressLow:  prdata = r_plo;
      btpc_pkg::RegPressHigh: prdata = r_phi;
      btpc_pkg::RegPressNine: prdata = {48'd0, r_p9};
      default:                prdata = '0;
    endcase
  end

  btpc_pkg::coeff_t c;
  assign c = '{t1: r_temp[15:0], t2: r_temp[31:16], t3: r_temp[47:32],
               p1: r_plo[15:0], p2: r_plo[31:16], p3: r_plo[47:32], p4: r_plo[63:48],
               p5: r_phi[15:0], p6: r_phi[31:16], p7: r_phi[47:32], p8: r_phi[63:48],
               p9: r_p9};

  logic f_valid, q_empty, q_full, f_adv, b_adv, q_rd, q_wr;
  logic [CW-1:0] q_cnt;
  btpc_pkg::job_t f_job, q_job;

  // Front advances whenever its last stage can leave into the queue.
  assign f_adv = !f_valid || !q_full || q_rd;
  assign raw.ready = f_adv && !rst;
  assign q_wr = f_valid && f_adv;

  btpc_front u_front (
    .clk, .rst, .c,
    .in_valid (raw.valid && raw.ready),
    .in_t     (raw.raw_temperature),
    .in_p     (raw.raw_pressure),
    .adv      (f_adv),
    .out_valid(f_valid),
    .out_job  (f_job)
  );

  btpc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk, .rst, .wr(q_wr), .wdata(f_job), .rd(q_rd),
    .empty(q_empty), .full(q_full), .count(q_cnt), .rdata(q_job)
  );

  logic b_valid;
  assign b_adv = !b_valid || res.ready;
  assign q_rd  = b_adv && !q_empty;

  logic [23:0] o_temp; logic [31:0] o_fine;
  btpc_back u_back (
    .clk, .rst, .c,
    .in_valid (q_rd),
    .in_job   (q_job),
    .adv      (b_adv),
    .out_valid(b_valid),
    .o_temp   (o_temp),
    .o_fine   (o_fine),
    .o_press  (res.pressure),
    .o_inv    (res.pressure_invalid)
  );

  assign res.valid            = b_valid;
  assign res.temperature      = o_temp;
  assign res.fine_temperature = o_fine;

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= CW'(QUEUE_DEPTH)) else $error("queue count too large");
  a_wr_full: assert property (@(posedge clk) disable iff (rst)
    q_wr && q_full |-> q_rd) else $error("write into full queue");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

[src/btpc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_front
// Pipelined temperature and pressure polynomial, up to four multiplies per stage,
// ending in a dividend/divisor job for the back part.
// ----------------------------------------------------------------------------
module btpc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire btpc_pkg::coeff_t c,
  input  wire logic             in_valid,
  input  wire logic [19:0]      in_t,
  input  wire logic [19:0]      in_p,
  input  wire logic             adv,
  output logic                  out_valid,
  output btpc_pkg::job_t        out_job
);
  localparam int unsigned NS = 7;

  logic [NS-1:0] v;
  // stage registers
  logic [31:0] s1_x, s1_d;  logic [19:0] s1_p;
  logic [31:0] s2_a, s2_dd; logic [19:0] s2_p;
  logic [31:0] s3_fine;     logic [19:0] s3_p;
  logic [31:0] s4_fine, s4_a, s4_sq, s4_temp; logic [19:0] s4_p;
  logic [31:0] s5_fine, s5_temp, s5_b1, s5_b2, s5_a1, s5_a2; logic [19:0] s5_p;
  logic [31:0] s6_fine, s6_temp, s6_b, s6_adiv; logic [19:0] s6_p;
  logic [31:0] s7_fine, s7_temp, s7_div, s7_pr;

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
  assign t1 = {16'd0, c.t1};
  assign t2 = btpc_pkg::sx16(c.t2);
  assign t3 = btpc_pkg::sx16(c.t3);
  assign p1 = {16'd0, c.p1};
  assign p2 = btpc_pkg::sx16(c.p2);
  assign p3 = btpc_pkg::sx16(c.p3);
  assign p4 = btpc_pkg::sx16(c.p4);
  assign p5 = btpc_pkg::sx16(c.p5);
  assign p6 = btpc_pkg::sx16(c.p6);

  logic [31:0] at, s3a;
  assign at  = {12'd0, in_t};
  assign s3a = btpc_pkg::asr(s3_fine, 1) - btpc_pkg::PressOffset;

  logic [31:0] s5_b, s5_a;
  assign s5_b = s5_b1 + (s5_b2 << 1);
  assign s5_a = btpc_pkg::asr(btpc_pkg::asr(s5_a1, 3) + btpc_pkg::asr(s5_a2, 1), 18);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x <= ((at >> 3) - (t1 << 1));
      s1_d <= (at >> 4) - t1;
      s1_p <= in_p;
      s2_a  <= btpc_pkg::asr(s1_x * t2, 11);
      s2_dd <= btpc_pkg::asr(s1_d * s1_d, 12);
      s2_p  <= s1_p;
      s3_fine <= s2_a + btpc_pkg::asr(s2_dd * t3, 14);
      s3_p    <= s2_p;
      s4_fine <= s3_fine;
      s4_temp <= btpc_pkg::asr(s3_fine * 32'd5 + btpc_pkg::TempRound, 8);
      s4_a    <= s3a;
      s4_sq   <= btpc_pkg::asr(s3a, 2) * btpc_pkg::asr(s3a, 2);
      s4_p    <= s3_p;
      s5_fine <= s4_fine;
      s5_temp <= s4_temp;
      s5_b1   <= btpc_pkg::asr(s4_sq, 11) * p6;
      s5_b2   <= s4_a * p5;
      s5_a1   <= p3 * btpc_pkg::asr(s4_sq, 13);
      s5_a2   <= p2 * s4_a;
      s5_p    <= s4_p;
      s6_fine <= s5_fine;
      s6_temp <= s5_temp;
      s6_b    <= btpc_pkg::asr(s5_b, 2) + (p4 << 16);
      s6_adiv <= btpc_pkg::DivBias + s5_a;
      s6_p    <= s5_p;
      s7_fine <= s6_fine;
      s7_temp <= s6_temp;
      s7_div  <= btpc_pkg::asr(s6_adiv * p1, 15);
      s7_pr   <= ((btpc_pkg::PressBase - {12'd0, s6_p}) - btpc_pkg::asr(s6_b, 12))
                 * btpc_pkg::PressScale;
    end
  end

  assign out_valid          = v[NS-1];
  assign out_job.temp       = s7_temp[btpc_pkg::TempW-1:0];
  assign out_job.fine       = s7_fine;
  assign out_job.divisor    = s7_div;
  assign out_job.dbl_after  = (s7_pr >= btpc_pkg::HalfRange);
  assign out_job.dividend   = (s7_pr < btpc_pkg::HalfRange) ? (s7_pr << 1) : s7_pr;

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) rst |=> v == '0)
    else $error("front pipeline not empty after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v)) else $error("front pipeline moved while stalled");
  a_shift: assert property (@(posedge clk) disable iff (rst)
    adv |=> v[1] == $past(v[0])) else $error("front valid did not shift");
`endif
endmodule
`default_nettype wire

[src/btpc_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_fifo
// Short job queue between the polynomial front and the divider back.
// ----------------------------------------------------------------------------
module btpc_fifo #(
  parameter int unsigned DEPTH = btpc_pkg::QDepth
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire btpc_pkg::job_t wdata,
  input  wire logic           rd,
  output logic                empty,
  output logic                full,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output btpc_pkg::job_t      rdata
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  btpc_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wp, rp;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (wr) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      count <= count + CW'(wr) - CW'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

`ifndef ASSERT_OFF
  a_no_over: assert property (@(posedge clk) disable iff (rst) full |-> !wr || rd)
    else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (rst) empty |-> !rd)
    else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count out of range");
`endif
endmodule
`default_nettype wire

[src/btpc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_back
// Pipelined radix-2 restoring divider, one quotient bit per stage, followed
// by the final pressure correction and an output register.
// ----------------------------------------------------------------------------
module btpc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire btpc_pkg::coeff_t c,
  input  wire logic             in_valid,
  input  wire btpc_pkg::job_t   in_job,
  input  wire logic             adv,
  output logic                  out_valid,
  output logic [23:0]           o_temp,
  output logic [31:0]           o_fine,
  output logic [31:0]           o_press,
  output logic                  o_inv
);
  localparam int unsigned N = btpc_pkg::DivW;
  localparam int unsigned NS = N + 3;

  btpc_pkg::job_t job [N+1];
  logic [31:0] rem [N+1];
  logic [31:0] quo [N+1];
  logic [NS-1:0] v;

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (adv) v <= {v[NS-2:0], in_valid};
  end

  assign job[0] = in_job;
  assign rem[0] = '0;
  assign quo[0] = in_job.dividend;

  for (genvar i = 0; i < N; i++) begin : g_div
    logic [32:0] sh, df;
    assign sh = {rem[i], quo[i][31]};
    assign df = sh - {1'b0, job[i].divisor};
    btpc_pkg::job_t jr;
    logic [31:0] rr, qr;
    always_ff @(posedge clk) begin
      if (adv) begin
        jr <= job[i];
        rr <= df[32] ? sh[31:0] : df[31:0];
        qr <= {quo[i][30:0], ~df[32]};
      end
    end
    assign job[i+1] = jr;
    assign rem[i+1] = rr;
    assign quo[i+1] = qr;
  end

  // Correction stage 1: quotient, its square and the P8 term.
  logic [31:0] q, e_pr, e_sq, e_b; logic e_inv; btpc_pkg::job_t e_j;
  assign q = job[N].dbl_after ? (quo[N] << 1) : quo[N];
  logic [31:0] q3;
  assign q3 = q >> 3;
  always_ff @(posedge clk) begin
    if (adv) begin
      e_j   <= job[N];
      e_inv <= (job[N].divisor == '0);
      e_pr  <= q;
      e_sq  <= (q3 * q3) >> 13;
      e_b   <= btpc_pkg::asr((q >> 2) * btpc_pkg::sx16(c.p8), 13);
    end
  end

  logic [31:0] f_pr, f_a, f_b; logic f_inv; btpc_pkg::job_t f_j;
  always_ff @(posedge clk) begin
    if (adv) begin
      f_j <= e_j; f_inv <= e_inv; f_pr <= e_pr; f_b <= e_b;
      f_a <= btpc_pkg::asr(btpc_pkg::sx16(c.p9) * e_sq, 12);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_temp  <= f_j.temp;
      o_fine  <= f_j.fine;
      o_inv   <= f_inv;
      o_press <= f_inv ? '0
               : f_pr + btpc_pkg::asr(f_a + f_b + btpc_pkg::sx16(c.p7), 4);
    end
  end

  assign out_valid = v[NS-1];

`ifndef ASSERT_OFF
  a_reset: assert property (@(posedge clk) rst |=> v == '0)
    else $error("divider pipeline not empty after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v)) else $error("divider pipeline moved while stalled");
  a_inv0: assert property (@(posedge clk) disable iff (rst)
    out_valid && o_inv |-> o_press == '0) else $error("invalid pressure not zero");
`endif
endmodule
`default_nettype wire

[dv/tb_baro_temp_pressure_compensation.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_baro_temp_pressure_compensation
// Drives raw reading pairs through the compensation block. Coefficient sets
// are written over the register port between phases. An internal predictor
// computes temperature, fine temperature and pressure for every accepted
// beat, and each result beat is checked in order against it.
// ----------------------------------------------------------------------------
module tb_baro_temp_pressure_compensation;

  localparam int unsigned Latency = 60;
  localparam longint unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [23:0] temperature;
    logic [31:0] fine;
    logic [31:0] pressure;
    logic        invalid;
  } comp_t;

  class comp_board;
    logic [47:0] temp_reg;
    logic [63:0] low_reg, high_reg;
    logic [15:0] nine_reg;
    comp_t pending[$];
    int errors;

    function logic [31:0] sext(input logic [15:0] v);
      return {{16{v[15]}}, v};
    endfunction

    function logic [31:0] sra(input logic [31:0] x, input int n);
      return 32'($signed(x) >>> n);
    endfunction

    function comp_t compensate(input logic [19:0] rt, input logic [19:0] rp);
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] at, ap, a, b, d, fine, pr, sq;
      comp_t r;
      t1 = {16'd0, temp_reg[15:0]};
      t2 = sext(temp_reg[31:16]);
      t3 = sext(temp_reg[47:32]);
      p1 = {16'd0, low_reg[15:0]};
      p2 = sext(low_reg[31:16]);
      p3 = sext(low_reg[47:32]);
      p4 = sext(low_reg[63:48]);
      p5 = sext(high_reg[15:0]);
      p6 = sext(high_reg[31:16]);
      p7 = sext(high_reg[47:32]);
      p8 = sext(high_reg[63:48]);
      p9 = sext(nine_reg);
      at = {12'd0, rt};
      ap = {12'd0, rp};
      a = sra(((at >> 3) - (t1 << 1)) * t2, 11);
      d = (at >> 4) - t1;
      b = sra(sra(d * d, 12) * t3, 14);
      fine = a + b;
      r.temperature = 24'(sra(fine * 32'd5 + 32'd128, 8));
      r.fine = fine;
      a = sra(fine, 1) - 32'd64000;
      sq = sra(a, 2) * sra(a, 2);
      b = sra(sq, 11) * p6;
      b = b + ((a * p5) << 1);
      b = sra(b, 2) + (p4 << 16);
      a = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * a, 1), 18);
      a = sra((32'd32768 + a) * p1, 15);
      pr = ((32'd1048576 - ap) - sra(b, 12)) * 32'd3125;
      r.invalid = (a == '0);
      if (a != '0) begin
        if (pr < 32'h8000_0000) pr = (pr << 1) / a;
        else pr = (pr / a) * 32'd2;
        a = sra(p9 * (((pr >> 3) * (pr >> 3)) >> 13), 12);
        b = sra((pr >> 2) * p8, 13);
        pr = pr + sra(a + b + p7, 4);
      end else begin
        pr = '0;
      end
      r.pressure = pr;
      return r;
    endfunction

    function void note_reading(input logic [19:0] rt, input logic [19:0] rp);
      pending.push_back(compensate(rt, rp));
    endfunction

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_result(input comp_t got);
      comp_t want;
      if (pending.size() == 0) begin
        report("unexpected beat", '0, '0);
        return;
      end
      want = pending.pop_front();
      if (got.temperature !== want.temperature)
        report("temperature", {8'd0, got.temperature}, {8'd0, want.temperature});
      if (got.fine !== want.fine) report("fine_temperature", got.fine, want.fine);
      if (got.pressure !== want.pressure) report("pressure", got.pressure, want.pressure);
      if (got.invalid !== want.invalid)
        report("pressure_invalid", {31'd0, got.invalid}, {31'd0, want.invalid});
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [btpc_pkg::AddrW-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  btpc_raw_if raw();
  btpc_res_if res();

  baro_temp_pressure_compensation dut (
    .clk, .rst, .raw(raw.sink), .res(res.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  comp_board board = new();
  longint unsigned cycles = 0;
  int hold_off = 0;     // cycles the result side must stay stalled
  bit calm = 0;         // no idling on either side while set

  initial begin
    raw.valid = 0;
    raw.raw_temperature = '0;
    raw.raw_pressure = '0;
    res.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("baro_temp_pressure_compensation test failed");
      $finish;
    end
  end

  // Result side: check accepted beats and drive ready.
  always @(posedge clk) begin
    if (!rst) begin
      if (res.valid && res.ready)
        board.check_result({res.temperature, res.fine_temperature, res.pressure,
                            res.pressure_invalid});
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        res.ready <= 0;
      end else begin
        res.ready <= calm || ($urandom_range(99) >= 35);
      end
    end
  end

  task write_reg(input logic [btpc_pkg::AddrW-1:0] addr, input logic [63:0] value);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (addr)
      btpc_pkg::RegTemp:      board.temp_reg = value[47:0];
      btpc_pkg::RegPressLow:  board.low_reg = value;
      btpc_pkg::RegPressHigh: board.high_reg = value;
      btpc_pkg::RegPressNine: board.nine_reg = value[15:0];
      default: ;
    endcase
  endtask

  task load_coeffs(input logic [47:0] tc, input logic [63:0] lo, input logic [63:0] hi,
                   input logic [15:0] p9);
    write_reg(btpc_pkg::RegTemp, {16'd0, tc});
    write_reg(btpc_pkg::RegPressLow, lo);
    write_reg(btpc_pkg::RegPressHigh, hi);
    write_reg(btpc_pkg::RegPressNine, {48'd0, p9});
  endtask

  task send_reading(input logic [19:0] rt, input logic [19:0] rp);
    while (!calm && $urandom_range(99) < 35) begin
      raw.valid <= 0;
      @(posedge clk);
    end
    raw.valid <= 1;
    raw.raw_temperature <= rt;
    raw.raw_pressure <= rp;
    @(posedge clk);
    while (!raw.ready) @(posedge clk);
    board.note_reading(rt, rp);
  endtask

  task drain;
    raw.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  // Typical datasheet-like coefficient set.
  task load_typical;
    load_coeffs({16'hFC18, 16'd26435, 16'd27504},
                {16'd2855, 16'd8004, -16'sd10685, 16'd36477},
                {16'd6000, -16'sd14600, 16'd15500, -16'sd7},
                -16'sd7);
  endtask

  task random_phase(input int count, input bit realistic);
    for (int i = 0; i < count; i++) begin
      if (realistic)
        send_reading(20'($urandom_range(560000, 480000)),
                     20'($urandom_range(450000, 300000)));
      else
        send_reading(20'($urandom), 20'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset coefficients: every divisor is zero.
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    drain();

    load_typical();
    send_reading(20'd519888, 20'd415148);
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'h00000);
    send_reading(20'h00000, 20'hFFFFF);
    send_reading(20'hAAAAA, 20'h55555);
    send_reading(20'h55555, 20'hAAAAA);
    drain();

    // Extremes of every coefficient field.
    load_coeffs('1, '1, '1, 16'hFFFF);
    send_reading(20'h00000, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'h00000);
    send_reading(20'h80000, 20'h80000);
    drain();
    load_coeffs({16'h8000, 16'h8000, 16'hFFFF}, {4{16'h7FFF}}, {4{16'h8000}}, 16'h7FFF);
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h12345, 20'hFEDCB);
    drain();
    // P1 zero forces a zero divisor even with sane readings.
    load_coeffs({16'hFC18, 16'd26435, 16'd27504}, 64'h0, {4{16'h1234}}, 16'h0001);
    send_reading(20'd519888, 20'd415148);
    send_reading(20'hFFFFF, 20'h00001);
    drain();

    // Back pressure: hold the result side while the source keeps offering.
    load_typical();
    calm = 1;
    hold_off = 300;
    random_phase(60, 1);
    drain();
    calm = 0;

    // Random phases with several coefficient sets.
    random_phase(250, 1);
    drain();
    for (int k = 0; k < 4; k++) begin
      load_coeffs(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                  16'($urandom));
      random_phase(80, 0);
      drain();
    end
    load_typical();
    calm = 1;
    random_phase(100, 1);
    calm = 0;
    random_phase(100, 0);
    drain();

    if (board.errors == 0) begin
      $display("baro_temp_pressure_compensation test passed");
    end else begin
      $display("baro_temp_pressure_compensation test failed");
    end
    $finish;
  end
endmodule

[sim.f]
src/btpc_pkg.sv
src/btpc_if.sv
src/btpc_front.sv
src/btpc_fifo.sv
src/btpc_back.sv
src/baro_temp_pressure_compensation.sv
dv/tb_baro_temp_pressure_compensation.sv
